### design/kfsd_pkg.sv
`timescale 1ns / 1ps

package kfsd_pkg;

	// field widths
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned POS_W   = 24;
	localparam int unsigned QUAT_W  = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned MOVE_W  = 50;
	localparam int unsigned COS_W   = 31;
	localparam int unsigned FRAC_W  = 17;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 50;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_FRAMES       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_FRAMES       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE_SQUARED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROTATION_COSINE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRACKED_FRACTION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INLIER_COUNT     = 3'd5;

	// 1.0 in unsigned Q1.30
	localparam logic [COS_W-1:0] COS_ONE = 31'h4000_0000;

	// register reset values
	localparam logic [COUNT_W-1:0] MAX_GAP_RESET = 16'd30;

	// identity orientation w, Q1.15
	localparam logic signed [QUAT_W-1:0] QUAT_W_IDENTITY = 16'sd32767;

endpackage

### design/keyframe_selection_decider_core.sv
// keyframe selection decider
// one frame transaction in on the in_valid/in_ready channel: index, position (Q12.12),
// orientation quaternion (Q1.15) and feature counts; one decision transaction out on
// out_valid/out_ready with is_key, gap, squared move, rotation cosine, inlier count
// and the three trigger flags
// the block holds the last keyframe's index, position and orientation; the first
// frame after reset is always a keyframe
// a frame passes the input register, then the result register, before out_valid
// rises; throughput: one frame per cycle while the receiver does not stall, set by
// the single decision stage that reads and updates the keyframe reference in the
// same cycle
// when the receiver stalls, the result register holds and one more frame may wait
// in the input register; in_ready drops only when both are full and out_ready is low
// reset clears both valid flags, forgets the keyframe and loads register defaults
// configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next
// edge and must only happen while no frame is in flight
`timescale 1ns / 1ps

module keyframe_selection_decider_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_write,
	input  logic [kfsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kfsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// frame input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [kfsd_pkg::FRAME_W-1:0]         frame_number,
	input  logic signed [kfsd_pkg::POS_W-1:0]    pos_x,
	input  logic signed [kfsd_pkg::POS_W-1:0]    pos_y,
	input  logic signed [kfsd_pkg::POS_W-1:0]    pos_z,
	input  logic signed [kfsd_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [kfsd_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [kfsd_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [kfsd_pkg::QUAT_W-1:0]   quat_z,
	input  logic [kfsd_pkg::COUNT_W-1:0]         feature_total,
	input  logic [kfsd_pkg::COUNT_W-1:0]         point_landmarks,
	input  logic [kfsd_pkg::COUNT_W-1:0]         line_landmarks,
	// decision output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 is_key,
	output logic [kfsd_pkg::FRAME_W-1:0]         gap_frames,
	output logic [kfsd_pkg::MOVE_W-1:0]          move_squared,
	output logic [kfsd_pkg::COS_W-1:0]           rotation_cosine,
	output logic [kfsd_pkg::COUNT_W-1:0]         inlier_count,
	output logic                                 forced_flag,
	output logic                                 motion_flag,
	output logic                                 quality_flag
);

	import kfsd_pkg::*;

	// configuration registers
	logic [COUNT_W-1:0] min_gap_frames_q;
	logic [COUNT_W-1:0] max_gap_frames_q;
	logic [MOVE_W-1:0]  min_move_squared_q;
	logic [COS_W-1:0]   max_rotation_cosine_q;
	logic [FRAC_W-1:0]  min_tracked_fraction_q;
	logic [COUNT_W-1:0] min_inlier_count_q;

	// keyframe reference
	logic                     have_key_q;
	logic [FRAME_W-1:0]       key_frame_q;
	logic signed [POS_W-1:0]  key_pos_x_q, key_pos_y_q, key_pos_z_q;
	logic signed [QUAT_W-1:0] key_quat_w_q, key_quat_x_q, key_quat_y_q, key_quat_z_q;

	// input register
	logic                     valid_s1;
	logic [FRAME_W-1:0]       frame_s1;
	logic signed [POS_W-1:0]  pos_x_s1, pos_y_s1, pos_z_s1;
	logic signed [QUAT_W-1:0] quat_w_s1, quat_x_s1, quat_y_s1, quat_z_s1;
	logic [COUNT_W-1:0]       total_s1, points_s1, lines_s1;

	// result register
	logic               valid_s2;
	logic               is_key_s2;
	logic [FRAME_W-1:0] gap_s2;
	logic [MOVE_W-1:0]  move_s2;
	logic [COS_W-1:0]   cos_s2;
	logic [COUNT_W-1:0] inlier_s2;
	logic               forced_s2, motion_s2, quality_s2;

	logic advance;

	// ---------------------------------------------------------------- handshake
	// the decision stage moves whenever the result register is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_frames_q       <= '0;
			max_gap_frames_q       <= MAX_GAP_RESET;
			min_move_squared_q     <= '0;
			max_rotation_cosine_q  <= COS_ONE;
			min_tracked_fraction_q <= '0;
			min_inlier_count_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MIN_GAP_FRAMES:       min_gap_frames_q       <= cfg_data[COUNT_W-1:0];
				CFG_MAX_GAP_FRAMES:       max_gap_frames_q       <= cfg_data[COUNT_W-1:0];
				CFG_MIN_MOVE_SQUARED:     min_move_squared_q     <= cfg_data[MOVE_W-1:0];
				CFG_MAX_ROTATION_COSINE:  max_rotation_cosine_q  <= cfg_data[COS_W-1:0];
				CFG_MIN_TRACKED_FRACTION: min_tracked_fraction_q <= cfg_data[FRAC_W-1:0];
				CFG_MIN_INLIER_COUNT:     min_inlier_count_q     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload only loads on an accepted transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1  <= frame_number;
			pos_x_s1  <= pos_x;
			pos_y_s1  <= pos_y;
			pos_z_s1  <= pos_z;
			quat_w_s1 <= quat_w;
			quat_x_s1 <= quat_x;
			quat_y_s1 <= quat_y;
			quat_z_s1 <= quat_z;
			total_s1  <= feature_total;
			points_s1 <= point_landmarks;
			lines_s1  <= line_landmarks;
		end
	end

	// ---------------------------------------------------------------- decision logic
	// position differences: 25-bit signed, magnitude fits 24 bits
	logic signed [POS_W:0] dx, dy, dz;
	logic [POS_W:0]        ndx, ndy, ndz;
	logic [POS_W-1:0]      ax, ay, az;
	logic [2*POS_W-1:0]    sqx, sqy, sqz;
	logic [MOVE_W-1:0]     move;

	assign dx  = {pos_x_s1[POS_W-1], pos_x_s1} - {key_pos_x_q[POS_W-1], key_pos_x_q};
	assign dy  = {pos_y_s1[POS_W-1], pos_y_s1} - {key_pos_y_q[POS_W-1], key_pos_y_q};
	assign dz  = {pos_z_s1[POS_W-1], pos_z_s1} - {key_pos_z_q[POS_W-1], key_pos_z_q};
	assign ndx = -dx;
	assign ndy = -dy;
	assign ndz = -dz;
	assign ax  = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
	assign ay  = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
	assign az  = dz[POS_W] ? ndz[POS_W-1:0] : dz[POS_W-1:0];
	assign sqx = ax * ax;
	assign sqy = ay * ay;
	assign sqz = az * az;
	// three squares below 2^48 each, so the sum never exceeds 50 bits
	assign move = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};

	// quaternion dot: four Q2.30 products, sum needs 34 bits signed
	localparam int unsigned DOT_W = 2 * QUAT_W + 2;
	logic signed [2*QUAT_W-1:0] pw, px, py, pz;
	logic signed [DOT_W-1:0]    dot;
	logic [DOT_W-1:0]           ndot;
	logic [DOT_W-2:0]           dot_mag;
	logic [COS_W-1:0]           cosv;

	assign pw   = quat_w_s1 * key_quat_w_q;
	assign px   = quat_x_s1 * key_quat_x_q;
	assign py   = quat_y_s1 * key_quat_y_q;
	assign pz   = quat_z_s1 * key_quat_z_q;
	assign dot  = DOT_W'(pw) + DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
	assign ndot = -dot;
	assign dot_mag = dot[DOT_W-1] ? ndot[DOT_W-2:0] : dot[DOT_W-2:0];
	// saturate at 1.0 for quaternions off unit length
	assign cosv = (dot_mag > (DOT_W-1)'(COS_ONE)) ? COS_ONE : dot_mag[COS_W-1:0];

	// landmark counts
	logic [COUNT_W:0]     tracked;
	logic [COUNT_W-1:0]   tracked_sat;
	logic [COUNT_W-1:0]   inliers;
	logic [2*COUNT_W-1:0] ratio_lhs;
	logic [2*COUNT_W:0]   ratio_rhs;
	logic                 ratio_low;

	assign tracked     = {1'b0, points_s1} + {1'b0, lines_s1};
	assign tracked_sat = (tracked < {1'b0, total_s1}) ? tracked[COUNT_W-1:0] : total_s1;
	assign inliers     = (points_s1 > lines_s1) ? points_s1 : lines_s1;
	assign ratio_lhs   = {tracked_sat, {COUNT_W{1'b0}}};
	assign ratio_rhs   = min_tracked_fraction_q * total_s1;
	// no features counts as a full ratio: only a limit of 1.0 or more fires
	assign ratio_low   = (total_s1 == '0) ? min_tracked_fraction_q[FRAC_W-1]
	                                      : ({1'b0, ratio_lhs} <= ratio_rhs);

	// tests
	logic [FRAME_W-1:0] gap;
	logic               tested;
	logic               forced, motion, quality, make_key;

	assign gap      = frame_s1 - key_frame_q;
	assign tested   = gap >= FRAME_W'(min_gap_frames_q);
	assign forced   = gap >= FRAME_W'(max_gap_frames_q);
	assign motion   = (move >= min_move_squared_q) || (cosv <= max_rotation_cosine_q);
	assign quality  = ratio_low || (inliers < min_inlier_count_q);
	assign make_key = !have_key_q || (tested && (forced || motion || quality));

	// ---------------------------------------------------------------- keyframe reference
	// updated as the frame leaves the decision stage, so the next frame sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_key_q   <= 1'b0;
			key_frame_q  <= '0;
			key_pos_x_q  <= '0;
			key_pos_y_q  <= '0;
			key_pos_z_q  <= '0;
			key_quat_w_q <= QUAT_W_IDENTITY;
			key_quat_x_q <= '0;
			key_quat_y_q <= '0;
			key_quat_z_q <= '0;
		end else if (advance && make_key) begin
			have_key_q   <= 1'b1;
			key_frame_q  <= frame_s1;
			key_pos_x_q  <= pos_x_s1;
			key_pos_y_q  <= pos_y_s1;
			key_pos_z_q  <= pos_z_s1;
			key_quat_w_q <= quat_w_s1;
			key_quat_x_q <= quat_x_s1;
			key_quat_y_q <= quat_y_s1;
			key_quat_z_q <= quat_z_s1;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_key_s2 <= make_key;
			if (!have_key_q) begin
				// first frame: everything but is_key reads zero
				gap_s2     <= '0;
				move_s2    <= '0;
				cos_s2     <= '0;
				inlier_s2  <= '0;
				forced_s2  <= 1'b0;
				motion_s2  <= 1'b0;
				quality_s2 <= 1'b0;
			end else if (!tested) begin
				// inside the minimum gap only the gap is reported
				gap_s2     <= gap;
				move_s2    <= '0;
				cos_s2     <= '0;
				inlier_s2  <= '0;
				forced_s2  <= 1'b0;
				motion_s2  <= 1'b0;
				quality_s2 <= 1'b0;
			end else begin
				gap_s2     <= gap;
				move_s2    <= move;
				cos_s2     <= cosv;
				inlier_s2  <= inliers;
				forced_s2  <= forced;
				motion_s2  <= motion;
				quality_s2 <= quality;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign is_key          = is_key_s2;
	assign gap_frames      = gap_s2;
	assign move_squared    = move_s2;
	assign rotation_cosine = cos_s2;
	assign inlier_count    = inlier_s2;
	assign forced_flag     = forced_s2;
	assign motion_flag     = motion_s2;
	assign quality_flag    = quality_s2;

endmodule

### design/kfsd_checker.sv
`timescale 1ns / 1ps

module kfsd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 is_key,
	input logic [kfsd_pkg::FRAME_W-1:0]         gap_frames,
	input logic [kfsd_pkg::COS_W-1:0]           rotation_cosine,
	input logic                                 forced_flag,
	input logic                                 motion_flag,
	input logic                                 quality_flag
);

	import kfsd_pkg::*;

	// any trigger makes a keyframe
	a_flag_implies_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (forced_flag || motion_flag || quality_flag) |-> is_key)
		else $error("trigger flag set without keyframe");

	// closeness never exceeds 1.0
	a_cos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rotation_cosine <= COS_ONE)
		else $error("rotation cosine above one");

	// stalled transaction holds its decision
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_key) && $stable(gap_frames))
		else $error("output changed while stalled");

endmodule

bind keyframe_selection_decider_core kfsd_checker u_kfsd_checker (.*);

### dv/keyframe_selection_decider_core_tb.sv
`timescale 1ns / 1ps

module keyframe_selection_decider_core_tb;

	import kfsd_pkg::*;

	// one frame transaction as driven on the input channel
	typedef struct packed {
		logic [FRAME_W-1:0]        number;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic signed [QUAT_W-1:0]  quat_w;
		logic signed [QUAT_W-1:0]  quat_x;
		logic signed [QUAT_W-1:0]  quat_y;
		logic signed [QUAT_W-1:0]  quat_z;
		logic [COUNT_W-1:0]        total;
		logic [COUNT_W-1:0]        points;
		logic [COUNT_W-1:0]        lines;
	} frame_t;

	// one decision transaction as seen on the output channel
	typedef struct packed {
		logic                is_key;
		logic [FRAME_W-1:0]  gap;
		logic [MOVE_W-1:0]   move;
		logic [COS_W-1:0]    cosine;
		logic [COUNT_W-1:0]  inliers;
		logic                forced;
		logic                motion;
		logic                quality;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [FRAME_W-1:0]          frame_number = '0;
	logic signed [POS_W-1:0]     pos_x = '0;
	logic signed [POS_W-1:0]     pos_y = '0;
	logic signed [POS_W-1:0]     pos_z = '0;
	logic signed [QUAT_W-1:0]    quat_w = '0;
	logic signed [QUAT_W-1:0]    quat_x = '0;
	logic signed [QUAT_W-1:0]    quat_y = '0;
	logic signed [QUAT_W-1:0]    quat_z = '0;
	logic [COUNT_W-1:0]          feature_total = '0;
	logic [COUNT_W-1:0]          point_landmarks = '0;
	logic [COUNT_W-1:0]          line_landmarks = '0;

	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        is_key;
	logic [FRAME_W-1:0]          gap_frames;
	logic [MOVE_W-1:0]           move_squared;
	logic [COS_W-1:0]            rotation_cosine;
	logic [COUNT_W-1:0]          inlier_count;
	logic                        forced_flag;
	logic                        motion_flag;
	logic                        quality_flag;

	keyframe_selection_decider_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.frame_number    (frame_number),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.quat_w          (quat_w),
		.quat_x          (quat_x),
		.quat_y          (quat_y),
		.quat_z          (quat_z),
		.feature_total   (feature_total),
		.point_landmarks (point_landmarks),
		.line_landmarks  (line_landmarks),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.is_key          (is_key),
		.gap_frames      (gap_frames),
		.move_squared    (move_squared),
		.rotation_cosine (rotation_cosine),
		.inlier_count    (inlier_count),
		.forced_flag     (forced_flag),
		.motion_flag     (motion_flag),
		.quality_flag    (quality_flag)
	);

	// shadow copy of the configuration registers, reset values
	logic [COUNT_W-1:0]  min_gap = '0;
	logic [COUNT_W-1:0]  max_gap = MAX_GAP_RESET;
	logic [MOVE_W-1:0]   min_move = '0;
	logic [COS_W-1:0]    max_cos = COS_ONE;
	logic [FRAC_W-1:0]   min_frac = '0;
	logic [COUNT_W-1:0]  inlier_floor = '0;

	// keyframe reference held by the predictor
	logic                        have_key = 1'b0;
	logic [FRAME_W-1:0]          key_number = '0;
	logic signed [POS_W-1:0]     key_pos [3] = '{default: '0};
	logic signed [QUAT_W-1:0]    key_quat [4] = '{QUAT_W_IDENTITY, '0, '0, '0};

	// frames waiting for the driver, decisions waiting for the output
	frame_t     frames_to_send [$];
	decision_t  decisions_due [$];
	frame_t     driven_frame;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	// random walk that the well-formed frame sequences follow
	logic [FRAME_W-1:0]        walk_number = 32'd1000;
	logic signed [POS_W-1:0]   walk_pos [3] = '{default: '0};
	logic signed [QUAT_W-1:0]  walk_quat [4] = '{QUAT_W_IDENTITY, '0, '0, '0};

	// idling per phase: none, sender only, receiver only, both
	int send_idle_table [4] = '{0, 62, 0, 28};
	int recv_stall_table [4] = '{0, 0, 62, 28};

	initial begin
		forever #1 clk = ~clk;
	end

	// decision for one frame, updates the keyframe reference on a key
	function automatic decision_t decide_keyframe(frame_t f);
		decision_t d;
		logic signed [POS_W-1:0]   p [3];
		logic signed [QUAT_W-1:0]  q [4];
		logic [COUNT_W-1:0]        larger;
		longint diff;
		longint sum_sq;
		longint dot;
		longint stable;
		longint clipped;
		d = '0;
		p[0] = f.pos_x;
		p[1] = f.pos_y;
		p[2] = f.pos_z;
		q[0] = f.quat_w;
		q[1] = f.quat_x;
		q[2] = f.quat_y;
		q[3] = f.quat_z;
		larger = (f.points > f.lines) ? f.points : f.lines;
		// first frame after reset is a keyframe with all metrics zero
		if (!have_key) begin
			d.is_key = 1'b1;
		end else begin
			d.gap = f.number - key_number;
			// inside the minimum gap only the gap is reported
			if (d.gap >= min_gap) begin
				sum_sq = 0;
				for (int i = 0; i < 3; i++) begin
					diff = longint'(p[i]) - longint'(key_pos[i]);
					sum_sq += diff * diff;
				end
				d.move = sum_sq[MOVE_W-1:0];
				dot = 0;
				for (int i = 0; i < 4; i++)
					dot += longint'(q[i]) * longint'(key_quat[i]);
				if (dot < 0)
					dot = -dot;
				// non-unit quaternions may exceed 1.0
				if (dot > longint'(COS_ONE))
					dot = longint'(COS_ONE);
				d.cosine = dot[COS_W-1:0];
				d.inliers = larger;
				d.forced = d.gap >= max_gap;
				d.motion = (d.move >= min_move) || (d.cosine <= max_cos);
				// no features reads as a tracked ratio of one
				if (f.total == 0) begin
					d.quality = min_frac >= 17'd65536;
				end else begin
					stable = longint'(f.points) + longint'(f.lines);
					clipped = (stable < longint'(f.total)) ? stable : longint'(f.total);
					d.quality = (clipped << 16) <= longint'(min_frac) * longint'(f.total);
				end
				d.quality = d.quality || (larger < inlier_floor);
				d.is_key = d.forced || d.motion || d.quality;
			end
		end
		if (d.is_key) begin
			have_key = 1'b1;
			key_number = f.number;
			for (int i = 0; i < 3; i++)
				key_pos[i] = p[i];
			for (int i = 0; i < 4; i++)
				key_quat[i] = q[i];
		end
		return d;
	endfunction

	function automatic frame_t make_frame(
		logic [FRAME_W-1:0] number,
		logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
		logic signed [POS_W-1:0] pz,
		logic signed [QUAT_W-1:0] qw, logic signed [QUAT_W-1:0] qx,
		logic signed [QUAT_W-1:0] qy, logic signed [QUAT_W-1:0] qz,
		logic [COUNT_W-1:0] total, logic [COUNT_W-1:0] points,
		logic [COUNT_W-1:0] lines);
		frame_t f;
		f.number = number;
		f.pos_x = px;
		f.pos_y = py;
		f.pos_z = pz;
		f.quat_w = qw;
		f.quat_x = qx;
		f.quat_y = qy;
		f.quat_z = qz;
		f.total = total;
		f.points = points;
		f.lines = lines;
		return f;
	endfunction

	// mostly a continuing camera track, sometimes pure noise
	function automatic frame_t random_frame();
		frame_t f;
		logic [31:0] r;
		logic [31:0] stride;
		int pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			r = $urandom;
			f.number = $urandom;
			f.pos_x = r[23:0];
			r = $urandom;
			f.pos_y = r[23:0];
			r = $urandom;
			f.pos_z = r[23:0];
			r = $urandom;
			f.quat_w = r[15:0];
			f.quat_x = r[31:16];
			r = $urandom;
			f.quat_y = r[15:0];
			f.quat_z = r[31:16];
			r = $urandom;
			f.total = r[15:0];
			f.points = r[31:16];
			r = $urandom;
			f.lines = r[15:0];
			return f;
		end
		// frame index: mostly consecutive, some skips, some wraps and jumps
		pick = $urandom_range(99);
		if (pick < 85)
			walk_number = walk_number + 32'd1;
		else if (pick < 95)
			walk_number = walk_number + $urandom_range(2, 50);
		else if (pick < 98)
			walk_number = 32'hFFFF_FFFF - $urandom_range(0, 20);
		else
			walk_number = $urandom;
		// position drifts by up to a metre per axis
		for (int i = 0; i < 3; i++) begin
			stride = $urandom_range(0, 8192);
			walk_pos[i] = walk_pos[i] + stride[POS_W-1:0] - 24'd4096;
		end
		// orientation drifts, now and then snaps back to a unit quaternion
		pick = $urandom_range(99);
		if (pick < 4) begin
			walk_quat = '{QUAT_W_IDENTITY, '0, '0, '0};
		end else if (pick < 7) begin
			walk_quat = '{16'sd23170, 16'sd0, 16'sd23170, 16'sd0};
		end else if (pick < 9) begin
			walk_quat = '{-16'sd32767, 16'sd0, 16'sd0, 16'sd0};
		end else begin
			for (int i = 0; i < 4; i++) begin
				stride = $urandom_range(0, 512);
				walk_quat[i] = walk_quat[i] + stride[QUAT_W-1:0] - 16'd256;
			end
		end
		f.number = walk_number;
		f.pos_x = walk_pos[0];
		f.pos_y = walk_pos[1];
		f.pos_z = walk_pos[2];
		f.quat_w = walk_quat[0];
		f.quat_x = walk_quat[1];
		f.quat_y = walk_quat[2];
		f.quat_z = walk_quat[3];
		// feature counts: zero, full range or a realistic spread
		pick = $urandom_range(99);
		r = $urandom;
		if (pick < 8)
			f.total = '0;
		else if (pick < 13)
			f.total = r[15:0];
		else
			f.total = COUNT_W'($urandom_range(1, 600));
		pick = $urandom_range(99);
		if (pick < 10) begin
			f.points = r[31:16];
			f.lines = COUNT_W'($urandom_range(0, 65535));
		end else begin
			f.points = COUNT_W'($urandom_range(0, f.total));
			f.lines = COUNT_W'($urandom_range(0, f.total / 2));
		end
		return f;
	endfunction

	// register write, mirrored into the predictor's shadow copy
	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_MIN_GAP_FRAMES:       min_gap = value[COUNT_W-1:0];
			CFG_MAX_GAP_FRAMES:       max_gap = value[COUNT_W-1:0];
			CFG_MIN_MOVE_SQUARED:     min_move = value[MOVE_W-1:0];
			CFG_MAX_ROTATION_COSINE:  max_cos = value[COS_W-1:0];
			CFG_MIN_TRACKED_FRACTION: min_frac = value[FRAC_W-1:0];
			CFG_MIN_INLIER_COUNT:     inlier_floor = value[COUNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic write_registers(input logic [CFG_DATA_W-1:0] gap_lo,
		input logic [CFG_DATA_W-1:0] gap_hi, input logic [CFG_DATA_W-1:0] move,
		input logic [CFG_DATA_W-1:0] cosine, input logic [CFG_DATA_W-1:0] frac,
		input logic [CFG_DATA_W-1:0] inliers);
		set_register(CFG_MIN_GAP_FRAMES, gap_lo);
		set_register(CFG_MAX_GAP_FRAMES, gap_hi);
		set_register(CFG_MIN_MOVE_SQUARED, move);
		set_register(CFG_MAX_ROTATION_COSINE, cosine);
		set_register(CFG_MIN_TRACKED_FRACTION, frac);
		set_register(CFG_MIN_INLIER_COUNT, inliers);
	endtask

	// a typical value, with its low or high end now and then
	function automatic logic [CFG_DATA_W-1:0] with_extremes(
		logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
		logic [CFG_DATA_W-1:0] typical);
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return lo;
		if (pick < 20)
			return hi;
		return typical;
	endfunction

	task automatic configure_phase(input int ph);
		logic [CFG_DATA_W-1:0] move;
		logic [CFG_DATA_W-1:0] cosine;
		move = CFG_DATA_W'($urandom_range(1, 100));
		move = move << 20;
		cosine = CFG_DATA_W'(COS_ONE) - CFG_DATA_W'($urandom_range(0, 1 << 22));
		case (ph)
			// everything at its low end: every tested frame is forced
			1: write_registers('0, '0, '0, '0, '0, '0);
			// every threshold but the minimum gap at its high end
			3: write_registers('0, 50'd65535, 50'h3_0000_0000_0000, CFG_DATA_W'(COS_ONE),
				50'd65536, 50'd65535);
			// minimum gap so long that only index jumps get tested
			5: write_registers(50'd65535, CFG_DATA_W'($urandom_range(1, 40)), move, cosine,
				CFG_DATA_W'($urandom_range(0, 65536)), CFG_DATA_W'($urandom_range(0, 100)));
			default: write_registers(
				with_extremes('0, 50'd65535, CFG_DATA_W'($urandom_range(0, 4))),
				with_extremes('0, 50'd65535, CFG_DATA_W'($urandom_range(1, 40))),
				with_extremes('0, 50'h3_0000_0000_0000, move),
				with_extremes('0, CFG_DATA_W'(COS_ONE), cosine),
				with_extremes('0, 50'd65536, CFG_DATA_W'($urandom_range(0, 65536))),
				with_extremes('0, 50'd65535, CFG_DATA_W'($urandom_range(0, 100))));
		endcase
	endtask

	// let everything in flight drain before touching the registers
	task automatic wait_idle();
		@(negedge clk);
		while (frames_to_send.size() != 0 || in_valid || decisions_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// driver: predicts on each accepted frame transaction, then offers the next
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				decisions_due.push_back(decide_keyframe(driven_frame));
			// payload only changes once the current transaction is taken
			if (!in_valid || in_ready) begin
				if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_frame = frames_to_send.pop_front();
					in_valid <= 1'b1;
					frame_number <= driven_frame.number;
					pos_x <= driven_frame.pos_x;
					pos_y <= driven_frame.pos_y;
					pos_z <= driven_frame.pos_z;
					quat_w <= driven_frame.quat_w;
					quat_x <= driven_frame.quat_x;
					quat_y <= driven_frame.quat_y;
					quat_z <= driven_frame.quat_z;
					feature_total <= driven_frame.total;
					point_landmarks <= driven_frame.points;
					line_landmarks <= driven_frame.lines;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each decision transaction against the oldest prediction
	always @(posedge clk) begin
		decision_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (decisions_due.size() == 0) begin
					$error("decision transaction with no frame pending");
					mismatch_count++;
				end else begin
					want = decisions_due.pop_front();
					compare_field("is_key", 64'(want.is_key), 64'(is_key));
					compare_field("gap_frames", 64'(want.gap), 64'(gap_frames));
					compare_field("move_squared", 64'(want.move), 64'(move_squared));
					compare_field("rotation_cosine", 64'(want.cosine),
						64'(rotation_cosine));
					compare_field("inlier_count", 64'(want.inliers), 64'(inlier_count));
					compare_field("forced_flag", 64'(want.forced), 64'(forced_flag));
					compare_field("motion_flag", 64'(want.motion), 64'(motion_flag));
					compare_field("quality_flag", 64'(want.quality), 64'(quality_flag));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: short min gap, forced after six, one square metre of move
		send_idle_pct = 28;
		recv_stall_pct = 28;
		write_registers(50'd2, 50'd6, 50'd1 << 24,
			CFG_DATA_W'(COS_ONE) - 50'd1048576, 50'd32768, 50'd10);
		@(negedge clk);
		// first frame is a keyframe
		frames_to_send.push_back(make_frame(100, 0, 0, 0, 32767, 0, 0, 0, 100, 80, 50));
		// inside the minimum gap
		frames_to_send.push_back(make_frame(101, 0, 0, 0, 32767, 0, 0, 0, 100, 80, 50));
		// tested, nothing fires
		frames_to_send.push_back(make_frame(102, 0, 0, 0, 32767, 0, 0, 0, 100, 80, 50));
		// gap reaches the maximum
		frames_to_send.push_back(make_frame(106, 0, 0, 0, 32767, 0, 0, 0, 100, 80, 50));
		// translation exactly at threshold
		frames_to_send.push_back(make_frame(108, 4096, 0, 0, 32767, 0, 0, 0, 100, 80, 50));
		// ninety degree turn about z
		frames_to_send.push_back(make_frame(110, 4096, 0, 0, 23170, 0, 0, 23170,
			100, 80, 50));
		// tracked ratio below half
		frames_to_send.push_back(make_frame(112, 4096, 0, 0, 23170, 0, 0, 23170,
			100, 20, 20));
		// no features counts as fully tracked
		frames_to_send.push_back(make_frame(114, 4096, 0, 0, 23170, 0, 0, 23170, 0, 50, 50));
		// too few inliers
		frames_to_send.push_back(make_frame(115, 4096, 0, 0, 23170, 0, 0, 23170, 20, 5, 9));
		// index below the keyframe wraps to a huge gap
		frames_to_send.push_back(make_frame(3, 4096, 0, 0, 32767, 32767, 32767, 32767,
			100, 80, 50));
		// non-unit quaternions saturate the closeness
		frames_to_send.push_back(make_frame(5, 4096, 0, 0, 32767, 32767, 32767, 32767,
			100, 80, 50));
		frames_to_send.push_back(make_frame(7, 4096, 0, 0, -32768, -32768, -32768, -32768,
			100, 80, 50));
		// position extremes and a zero quaternion
		frames_to_send.push_back(make_frame(9, -8388608, 8388607, -8388608, 0, 0, 0, 0,
			100, 80, 50));
		frames_to_send.push_back(make_frame(11, 8388607, -8388608, 8388607, 32767, 0, 0, 0,
			65535, 65535, 65535));
		frames_to_send.push_back(make_frame(13, 8388607, -8388608, 8388607, -32768, 0, 0, 0,
			65535, 0, 0));
		// index extremes across the wrap
		frames_to_send.push_back(make_frame(32'hFFFF_FFFF, 0, 0, 0, 32767, 0, 0, 0,
			100, 80, 50));
		frames_to_send.push_back(make_frame(32'h0000_0001, 0, 0, 0, 32767, 0, 0, 0,
			100, 80, 50));
		frames_to_send.push_back(make_frame(32'h0000_0002, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// ratio limit of one: no features and full tracking both fire
		set_register(CFG_MIN_GAP_FRAMES, '0);
		set_register(CFG_MIN_TRACKED_FRACTION, 50'd65536);
		@(negedge clk);
		frames_to_send.push_back(make_frame(20, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
		frames_to_send.push_back(make_frame(21, 0, 0, 0, 32767, 0, 0, 0,
			65535, 65535, 65535));
		wait_idle();

		// random phases, cycling through the idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			configure_phase(ph);
			@(negedge clk);
			send_idle_pct = send_idle_table[ph % 4];
			recv_stall_pct = recv_stall_table[ph % 4];
			for (int n = 0; n < 150; n++)
				frames_to_send.push_back(random_frame());
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && decisions_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/kfsd_pkg.sv
design/keyframe_selection_decider_core.sv
design/kfsd_checker.sv
dv/keyframe_selection_decider_core_tb.sv
